// ===== design/vbf_pkg.sv =====
// Package for the VLIW bundle former: request and event payload types,
// configuration struct, register codes and the hint rule.
// Depends on nothing; every other design file refers to it by scoped names.
package vbf_pkg;

	localparam int LANE_REGS   = 4;
	localparam int MAX_LANES   = 4;
	localparam int LANE_LIMIT  = (MAX_LANES < LANE_REGS) ? MAX_LANES : LANE_REGS;
	localparam int NUM_CLASSES = 10;
	localparam int MAX_RES     = 3;

	localparam logic [2:0] REG_BUNDLE_WIDTH = 3'd0;
	localparam logic [2:0] REG_LANE0_CLS    = 3'd1;
	localparam logic [2:0] REG_LANE1_CLS    = 3'd2;
	localparam logic [2:0] REG_LANE2_CLS    = 3'd3;
	localparam logic [2:0] REG_LANE3_CLS    = 3'd4;
	localparam logic [2:0] REG_ALLOW_SHORT  = 3'd5;
	localparam logic [2:0] REG_HINT_SINGLE  = 3'd6;

	typedef enum logic [1:0] {
		EV_PLACED    = 2'd0,
		EV_CLOSED    = 2'd1,
		EV_UNBUNDLED = 2'd2
	} event_t;

	typedef struct packed {
		logic       operation;
		logic [3:0] op_class;
		logic [6:0] src_reg_a;
		logic [6:0] src_reg_b;
		logic [6:0] src_reg_c;
		logic [6:0] dst_reg_a;
		logic [6:0] dst_reg_b;
	} instr_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] lane;
		logic [2:0] bundle_size;
		logic       emit_hint;
		logic       last;
	} evt_t;

	// All results caused by one request, in delivery order.
	typedef struct packed {
		logic [1:0]         cnt;
		evt_t [MAX_RES-1:0] res;
	} grp_t;

	typedef struct packed {
		logic [2:0]                bundle_width;
		logic [LANE_REGS-1:0][9:0] lane_cls;
		logic                      allow_short;
		logic                      hint_single;
	} cfg_t;

	function automatic logic bundle_hint(input logic [2:0] n, input logic [2:0] w,
			input logic allow_short, input logic hint_single);
		logic h;
		if (n >= w) begin
			h = 1'b1;
		end else if (n >= 3'd2) begin
			h = allow_short;
		end else begin
			h = hint_single;
		end
		return h;
	endfunction

	function automatic evt_t close_evt(input logic [2:0] n, input logic hint,
			input logic is_last);
		evt_t e;
		e.event_res   = EV_CLOSED;
		e.lane        = 2'd0;
		e.bundle_size = n;
		e.emit_hint   = hint;
		e.last        = is_last;
		return e;
	endfunction

endpackage

// ===== design/vbf_front.sv =====
// Front end of the bundle former: accepts requests, checks register hazards,
// picks a lane and updates the open-bundle state. Depends on vbf_pkg.
module vbf_front #(
	parameter int REG_IDS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vbf_pkg::cfg_t cfg,
	input  logic          instr_valid,
	input  vbf_pkg::instr_t instr,
	output logic          instr_stall,
	input  logic          q_full,
	output logic          push,
	output vbf_pkg::grp_t grp
);

	localparam int SLOTS = vbf_pkg::LANE_LIMIT;
	localparam int SW    = $clog2(SLOTS);

	// one slot per instruction of the open bundle; count_q marks the live ones
	logic [6:0] src_q [SLOTS][3];
	logic [6:0] dst_q [SLOTS][2];
	logic [vbf_pkg::LANE_REGS-1:0] busy_q, busy_n, busy_eff, legal, cand;
	logic [2:0] count_q, count_n, cnt_base, cnt_new, w;
	logic [6:0] srcs [3];
	logic [6:0] dsts [2];
	logic [6:0] sreg [3];
	logic [6:0] dreg [2];
	logic accept, dep, restart, pre, placed, post, wr_slot;
	logic [1:0] lane;
	logic [SW-1:0] slot_idx;
	vbf_pkg::evt_t main_e, pre_e, post_e, bar_e;

	assign instr_stall = q_full;
	assign accept      = instr_valid && !q_full;

	assign srcs[0] = instr.src_reg_a;
	assign srcs[1] = instr.src_reg_b;
	assign srcs[2] = instr.src_reg_c;
	assign dsts[0] = instr.dst_reg_a;
	assign dsts[1] = instr.dst_reg_b;

	// clamp the configured width to 1 .. lane limit
	always_comb begin
		if (cfg.bundle_width == 3'd0) begin
			w = 3'd1;
		end else if (32'(cfg.bundle_width) > vbf_pkg::LANE_LIMIT) begin
			w = 3'(vbf_pkg::LANE_LIMIT);
		end else begin
			w = cfg.bundle_width;
		end
	end

	// registers out of range count as none
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sreg[i] = (32'(srcs[i]) < REG_IDS) ? srcs[i] : 7'd0;
		end
		for (int i = 0; i < 2; i++) begin
			dreg[i] = (32'(dsts[i]) < REG_IDS) ? dsts[i] : 7'd0;
		end
	end

	// RAW, WAW and WAR against every live slot of the open bundle
	always_comb begin
		dep = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (32'(s) < 32'(count_q)) begin
				for (int j = 0; j < 2; j++) begin
					for (int i = 0; i < 3; i++) begin
						if (sreg[i] != 7'd0 && sreg[i] == dst_q[s][j]) dep = 1'b1;
					end
					for (int i = 0; i < 2; i++) begin
						if (dreg[i] != 7'd0 && dreg[i] == dst_q[s][j]) dep = 1'b1;
					end
				end
				for (int k = 0; k < 3; k++) begin
					for (int i = 0; i < 2; i++) begin
						if (dreg[i] != 7'd0 && dreg[i] == src_q[s][k]) dep = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < vbf_pkg::LANE_REGS; l++) begin
			legal[l] = (32'(instr.op_class) < vbf_pkg::NUM_CLASSES) && (l < 32'(w)) &&
				((32'(instr.op_class) < vbf_pkg::NUM_CLASSES) ?
				cfg.lane_cls[l][instr.op_class] : 1'b0);
		end
	end

	// restart: hazard, or no free legal lane in the open bundle
	assign restart  = dep || ((legal & ~busy_q) == '0);
	assign pre      = restart && (count_q != 3'd0);
	assign busy_eff = restart ? '0 : busy_q;
	assign cand     = legal & ~busy_eff;
	assign placed   = |cand;
	assign cnt_base = restart ? 3'd0 : count_q;
	assign cnt_new  = cnt_base + 3'd1;
	assign post     = placed && (cnt_new >= w);

	always_comb begin
		lane = 2'd0;
		for (int l = vbf_pkg::LANE_REGS - 1; l >= 0; l--) begin
			if (cand[l]) lane = 2'(l);
		end
	end

	always_comb begin
		main_e.event_res   = placed ? vbf_pkg::EV_PLACED : vbf_pkg::EV_UNBUNDLED;
		main_e.lane        = placed ? lane : 2'd0;
		main_e.bundle_size = 3'd0;
		main_e.emit_hint   = 1'b0;
		main_e.last        = !post;
		pre_e  = vbf_pkg::close_evt(count_q,
			vbf_pkg::bundle_hint(count_q, w, cfg.allow_short, cfg.hint_single), 1'b0);
		post_e = vbf_pkg::close_evt(cnt_new,
			vbf_pkg::bundle_hint(cnt_new, w, cfg.allow_short, cfg.hint_single), 1'b1);
		bar_e  = vbf_pkg::close_evt(count_q,
			vbf_pkg::bundle_hint(count_q, w, cfg.allow_short, cfg.hint_single), 1'b1);
	end

	always_comb begin
		grp.res = '0;
		if (instr.operation) begin
			grp.res[0] = bar_e;
			grp.cnt    = (count_q != 3'd0) ? 2'd1 : 2'd0;
		end else begin
			grp.res[0] = pre ? pre_e : main_e;
			grp.res[1] = pre ? main_e : post_e;
			grp.res[2] = post_e;
			grp.cnt    = 2'd1 + 2'(pre) + 2'(post);
		end
	end

	assign push = accept && (grp.cnt != 2'd0);

	// next bundle state
	always_comb begin
		busy_n  = busy_eff;
		count_n = cnt_base;
		if (instr.operation || post) begin
			busy_n  = '0;
			count_n = 3'd0;
		end else if (placed) begin
			busy_n[lane] = 1'b1;
			count_n      = cnt_new;
		end
	end

	// record the placed instruction's registers in the next free slot
	assign wr_slot  = accept && !instr.operation && placed;
	assign slot_idx = cnt_base[SW-1:0];

	always_ff @(posedge clk) begin
		if (wr_slot) begin
			for (int i = 0; i < 3; i++) src_q[slot_idx][i] <= sreg[i];
			for (int i = 0; i < 2; i++) dst_q[slot_idx][i] <= dreg[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			count_q <= 3'd0;
		end else if (accept) begin
			busy_q  <= busy_n;
			count_q <= count_n;
		end
	end

endmodule

// ===== design/vbf_queue.sv =====
// Four-entry queue of result groups between front and back end.
// Depends on vbf_pkg for the group type.
module vbf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vbf_pkg::grp_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output vbf_pkg::grp_t rdata
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	vbf_pkg::grp_t     mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== design/vbf_back.sv =====
// Back end of the bundle former: unrolls each queued group into single
// events through the output register. Depends on vbf_pkg.
module vbf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  vbf_pkg::grp_t q_data,
	output logic          pop,
	output logic          evt_valid,
	input  logic          evt_stall,
	output vbf_pkg::evt_t evt
);

	logic [1:0]    idx_q;
	logic          valid_q, load, group_done;
	vbf_pkg::evt_t evt_q;

	assign load       = q_nonempty && (!valid_q || !evt_stall);
	assign group_done = (idx_q == q_data.cnt - 2'd1);
	assign pop        = load && group_done;
	assign evt_valid  = valid_q;
	assign evt        = evt_q;

	always_ff @(posedge clk) begin
		if (load) evt_q <= q_data.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= group_done ? 2'd0 : idx_q + 2'd1;
			end else if (!evt_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/vliw_bundle_former.sv =====
// Top level of the VLIW bundle former: APB register file, front end, queue
// and back end. Depends on vbf_pkg, vbf_front, vbf_queue and vbf_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   instr   | in        | instr_valid/instr_stall | vbf_pkg::instr_t request
//   evt     | out       | evt_valid/evt_stall     | vbf_pkg::evt_t event
//   apb     | in        | psel/penable/pready     | paddr, pwdata, prdata
//
// Flow: a request is classified in the cycle it is accepted and its group
//   enters the queue at that edge; its events are then loaded into the output
//   register one per cycle while evt_stall is low, and a request makes 0 to 3
//   events (one per result in its group).
//   Back-to-back requests are taken every cycle while the four-group queue
//   has room; the event port, not the hazard check, sets the sustained rate.
// Reset: arst_n clears the bundle count, busy lanes, queue and output valid
//   at once and loads the register defaults; the register slots of the open
//   bundle are marked stale by the zero count, so no clearing pass follows.
// Stalls: evt_stall holds the output register; the queue absorbs up to four
//   groups before instr_stall rises.
module vliw_bundle_former #(
	parameter int REG_IDS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            instr_valid,
	output logic            instr_stall,
	input  vbf_pkg::instr_t instr,
	output logic            evt_valid,
	input  logic            evt_stall,
	output vbf_pkg::evt_t   evt,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	vbf_pkg::cfg_t cfg_q;
	vbf_pkg::grp_t f_grp, q_grp;
	logic          f_push, q_full, q_nonempty, b_pop, cfg_wr;
	logic [2:0]    reg_idx;

	// Register file: word addressed, writes complete in the access phase.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bundle_width <= 3'd4;
			cfg_q.lane_cls     <= {vbf_pkg::LANE_REGS{10'h3ff}};
			cfg_q.allow_short  <= 1'b1;
			cfg_q.hint_single  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				vbf_pkg::REG_BUNDLE_WIDTH: cfg_q.bundle_width <= pwdata[2:0];
				vbf_pkg::REG_LANE0_CLS:    cfg_q.lane_cls[0]  <= pwdata[9:0];
				vbf_pkg::REG_LANE1_CLS:    cfg_q.lane_cls[1]  <= pwdata[9:0];
				vbf_pkg::REG_LANE2_CLS:    cfg_q.lane_cls[2]  <= pwdata[9:0];
				vbf_pkg::REG_LANE3_CLS:    cfg_q.lane_cls[3]  <= pwdata[9:0];
				vbf_pkg::REG_ALLOW_SHORT:  cfg_q.allow_short  <= pwdata[0];
				vbf_pkg::REG_HINT_SINGLE:  cfg_q.hint_single  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back: unused addresses return zero.
	always_comb begin
		unique case (reg_idx)
			vbf_pkg::REG_BUNDLE_WIDTH: prdata = {29'd0, cfg_q.bundle_width};
			vbf_pkg::REG_LANE0_CLS:    prdata = {22'd0, cfg_q.lane_cls[0]};
			vbf_pkg::REG_LANE1_CLS:    prdata = {22'd0, cfg_q.lane_cls[1]};
			vbf_pkg::REG_LANE2_CLS:    prdata = {22'd0, cfg_q.lane_cls[2]};
			vbf_pkg::REG_LANE3_CLS:    prdata = {22'd0, cfg_q.lane_cls[3]};
			vbf_pkg::REG_ALLOW_SHORT:  prdata = {31'd0, cfg_q.allow_short};
			vbf_pkg::REG_HINT_SINGLE:  prdata = {31'd0, cfg_q.hint_single};
			default:                   prdata = 32'd0;
		endcase
	end

	// Front: hazard check, lane pick and bundle state, one request a cycle while the queue has room.
	vbf_front #(
		.REG_IDS(REG_IDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.instr_valid (instr_valid),
		.instr       (instr),
		.instr_stall (instr_stall),
		.q_full      (q_full),
		.push        (f_push),
		.grp         (f_grp)
	);

	// Queue: decouple the front from output back-pressure.
	vbf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    (f_grp),
		.full     (q_full),
		.pop      (b_pop),
		.nonempty (q_nonempty),
		.rdata    (q_grp)
	);

	// Back: drain each group one event at a time.
	vbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_grp),
		.pop        (b_pop),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt)
	);

endmodule

// ===== design/vbf_checker.sv =====
// Port-level checks for the bundle former, bound to the top level.
// Depends on vbf_pkg and vliw_bundle_former.
module vbf_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            evt_valid,
	input logic            evt_stall,
	input vbf_pkg::evt_t   evt,
	input logic            pready
);

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid && $stable(evt))
		else $error("stalled event changed");

	a_placed_fields: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.event_res == vbf_pkg::EV_PLACED |->
		evt.bundle_size == 3'd0 && evt.emit_hint == 1'b0)
		else $error("placed event carries close fields");

	a_close_size: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.event_res == vbf_pkg::EV_CLOSED |->
		evt.bundle_size != 3'd0 && evt.bundle_size <= 3'd4)
		else $error("closed bundle size out of range");

	a_unbundled_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.event_res == vbf_pkg::EV_UNBUNDLED |->
		evt.last && evt.lane == 2'd0)
		else $error("unbundled event not final");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind vliw_bundle_former vbf_checker u_vbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_stall (evt_stall),
	.evt       (evt),
	.pready    (pready)
);

// ===== tb/tb_vliw_bundle_former.sv =====
// Self-checking bench for vliw_bundle_former: drives requests and APB register
// writes, predicts every bundle event and checks the event port in order.
// Depends on vbf_pkg and the vliw_bundle_former RTL only.
module tb_vliw_bundle_former;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest legal quiet stretch is the receiver hold-off; allow several times that.
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 150;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            instr_valid = 1'b0;
	logic            instr_stall;
	vbf_pkg::instr_t instr       = '0;
	logic            evt_valid;
	logic            evt_stall   = 1'b0;
	vbf_pkg::evt_t   evt;
	logic            psel        = 1'b0;
	logic            penable     = 1'b0;
	logic            pwrite      = 1'b0;
	logic [4:0]      paddr       = '0;
	logic [31:0]     pwdata      = '0;
	logic [31:0]     prdata;
	logic            pready;

	vliw_bundle_former dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr      (instr),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Bundle predictor: configuration copy and open-bundle state
	// ------------------------------------------------------------------
	logic [2:0]                         cfg_width       = 3'd4;
	logic [vbf_pkg::LANE_REGS-1:0][9:0] cfg_lane_cls    = {vbf_pkg::LANE_REGS{10'h3FF}};
	logic                               cfg_allow_short = 1'b1;
	logic                               cfg_hint_single = 1'b0;

	logic [127:0] bundle_reads  = '0;
	logic [127:0] bundle_writes = '0;
	logic [3:0]   lanes_taken   = '0;
	int unsigned  bundle_fill   = 0;

	// Events still owed by the block, oldest first.
	vbf_pkg::evt_t expected_events[$];
	int            mismatches = 0;

	// Idle controls shared between the stimulus and the stall process.
	bit tx_idle_en  = 1'b1;
	bit rx_idle_en  = 1'b1;
	int rx_hold_req = 0;

	// Append one event at the tail of an event queue.
	function automatic void queue_evt(ref vbf_pkg::evt_t q[$], input vbf_pkg::evt_t e);
		q.insert(q.size(), e);
	endfunction

	// Clamp the programmed width: zero acts as one, large values saturate.
	function automatic int unsigned lanes_in_use();
		int unsigned w;
		w = cfg_width;
		if (w < 1) w = 1;
		if (w > vbf_pkg::LANE_LIMIT) w = vbf_pkg::LANE_LIMIT;
		return w;
	endfunction

	// Close the open bundle; an empty bundle closes silently.
	function automatic bit close_bundle(output vbf_pkg::evt_t e);
		e = '0;
		if (bundle_fill == 0) return 1'b0;
		e.event_res   = vbf_pkg::EV_CLOSED;
		e.bundle_size = 3'(bundle_fill);
		if (bundle_fill >= lanes_in_use()) begin
			e.emit_hint = 1'b1;
		end else if (bundle_fill >= 2) begin
			e.emit_hint = cfg_allow_short;
		end else begin
			e.emit_hint = cfg_hint_single;
		end
		bundle_reads  = '0;
		bundle_writes = '0;
		lanes_taken   = '0;
		bundle_fill   = 0;
		return 1'b1;
	endfunction

	// Lowest free lane legal for the class, or -1; unknown classes match nothing.
	function automatic int free_lane(logic [3:0] cls);
		if (cls >= vbf_pkg::NUM_CLASSES) return -1;
		for (int l = 0; l < lanes_in_use(); l++) begin
			if (cfg_lane_cls[l][cls] && !lanes_taken[l]) return l;
		end
		return -1;
	endfunction

	// Work out the events one accepted request causes and queue them.
	function automatic void predict_events(vbf_pkg::instr_t x);
		vbf_pkg::evt_t grp[$];
		vbf_pkg::evt_t e;
		logic [6:0]    srcs[3];
		logic [6:0]    dsts[2];
		bit            conflict;
		int            l;
		conflict = 1'b0;
		if (x.operation) begin
			if (close_bundle(e)) queue_evt(grp, e);
		end else begin
			srcs = '{x.src_reg_a, x.src_reg_b, x.src_reg_c};
			dsts = '{x.dst_reg_a, x.dst_reg_b};
			// RAW against bundle writes; WAR and WAW against reads and writes
			foreach (srcs[i]) begin
				if (srcs[i] != 0 && bundle_writes[srcs[i]]) conflict = 1'b1;
			end
			foreach (dsts[i]) begin
				if (dsts[i] != 0 && (bundle_writes[dsts[i]] || bundle_reads[dsts[i]]))
					conflict = 1'b1;
			end
			if (conflict && close_bundle(e)) queue_evt(grp, e);
			// No lane: close and retry once
			l = free_lane(x.op_class);
			if (l < 0) begin
				if (close_bundle(e)) queue_evt(grp, e);
				l = free_lane(x.op_class);
			end
			e = '0;
			if (l < 0) begin
				e.event_res = vbf_pkg::EV_UNBUNDLED;
				queue_evt(grp, e);
			end else begin
				e.event_res = vbf_pkg::EV_PLACED;
				e.lane      = l[1:0];
				queue_evt(grp, e);
				lanes_taken[l] = 1'b1;
				bundle_fill++;
				foreach (srcs[i]) begin
					if (srcs[i] != 0) bundle_reads[srcs[i]] = 1'b1;
				end
				foreach (dsts[i]) begin
					if (dsts[i] != 0) bundle_writes[dsts[i]] = 1'b1;
				end
				// Full, or past a width lowered while the bundle was open
				if (bundle_fill >= lanes_in_use() && close_bundle(e)) queue_evt(grp, e);
			end
		end
		if (grp.size() > 0) begin
			e = grp.pop_back();
			e.last = 1'b1;
			queue_evt(grp, e);
		end
		foreach (grp[i]) queue_evt(expected_events, grp[i]);
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_length(bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Small register pool so hazards are frequent; full range now and then.
	function automatic logic [6:0] rand_reg();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 7'd0;
		if (r < 8) return 7'($urandom_range(1, 12));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic vbf_pkg::instr_t rand_instr();
		vbf_pkg::instr_t x;
		x.operation = ($urandom_range(0, 9) == 0);
		x.op_class  = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(10, 15))
		                                           : 4'($urandom_range(0, 9));
		x.src_reg_a = rand_reg();
		x.src_reg_b = rand_reg();
		x.src_reg_c = rand_reg();
		x.dst_reg_a = rand_reg();
		x.dst_reg_b = rand_reg();
		return x;
	endfunction

	function automatic vbf_pkg::instr_t make_instr(logic barrier, logic [3:0] cls,
			logic [6:0] sa, logic [6:0] sb, logic [6:0] sc, logic [6:0] da, logic [6:0] db);
		vbf_pkg::instr_t x;
		x.operation = barrier;
		x.op_class  = cls;
		x.src_reg_a = sa;
		x.src_reg_b = sb;
		x.src_reg_c = sc;
		x.dst_reg_a = da;
		x.dst_reg_b = db;
		return x;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one request, hold it until taken, predict, then maybe idle.
	// Valid stays high across back-to-back requests.
	task automatic send_instr(vbf_pkg::instr_t x);
		int gap;
		instr       <= x;
		instr_valid <= 1'b1;
		do @(posedge clk); while (instr_stall);
		predict_events(x);
		gap = idle_length(tx_idle_en);
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		instr_valid <= 1'b0;
	endtask

	// Wait until every owed event has come, then let trailing requests
	// that make no event clear the pipeline.
	task automatic wait_drained();
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count);
		repeat (count) send_instr(rand_instr());
	endtask

	// APB write: setup phase, then access until pready, then idle with psel low;
	// mirror into the predictor.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			vbf_pkg::REG_BUNDLE_WIDTH: cfg_width       = value[2:0];
			vbf_pkg::REG_LANE0_CLS:    cfg_lane_cls[0] = value[9:0];
			vbf_pkg::REG_LANE1_CLS:    cfg_lane_cls[1] = value[9:0];
			vbf_pkg::REG_LANE2_CLS:    cfg_lane_cls[2] = value[9:0];
			vbf_pkg::REG_LANE3_CLS:    cfg_lane_cls[3] = value[9:0];
			vbf_pkg::REG_ALLOW_SHORT:  cfg_allow_short = value[0];
			vbf_pkg::REG_HINT_SINGLE:  cfg_hint_single = value[0];
			default: ;
		endcase
	endtask

	// Quiesce the request side, then program every register.
	// The open bundle survives, so a lowered width can land mid-bundle.
	task automatic apply_settings(logic [2:0] width, logic [9:0] l0, logic [9:0] l1,
			logic [9:0] l2, logic [9:0] l3, logic allow_short, logic hint_single);
		stop_sending();
		wait_drained();
		write_reg(vbf_pkg::REG_BUNDLE_WIDTH, 32'(width));
		write_reg(vbf_pkg::REG_LANE0_CLS, 32'(l0));
		write_reg(vbf_pkg::REG_LANE1_CLS, 32'(l1));
		write_reg(vbf_pkg::REG_LANE2_CLS, 32'(l2));
		write_reg(vbf_pkg::REG_LANE3_CLS, 32'(l3));
		write_reg(vbf_pkg::REG_ALLOW_SHORT, 32'(allow_short));
		write_reg(vbf_pkg::REG_HINT_SINGLE, 32'(hint_single));
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hazards, lane fill, unknown classes, barriers and field extremes
	// under the reset settings.
	task automatic test_directed();
		send_instr(make_instr(1'b1, 4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));       // barrier, no bundle
		send_instr(make_instr(1'b0, 4'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0));
		send_instr(make_instr(1'b0, 4'd9, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0));       // RAW
		send_instr(make_instr(1'b0, 4'd3, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0));       // WAR
		send_instr(make_instr(1'b0, 4'd4, 7'd0, 7'd0, 7'd0, 7'd1, 7'd0));       // WAW
		send_instr(make_instr(1'b0, 4'd5, 7'd127, 7'd127, 7'd127, 7'd126, 7'd0));
		send_instr(make_instr(1'b0, 4'd6, 7'd125, 7'd0, 7'd0, 7'd124, 7'd0));
		send_instr(make_instr(1'b0, 4'd7, 7'd0, 7'd0, 7'd0, 7'd123, 7'd0));     // fills lane 3
		send_instr(make_instr(1'b0, 4'd15, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127));
		send_instr(make_instr(1'b0, 4'd1, 7'd0, 7'd0, 7'd0, 7'd2, 7'd0));
		send_instr(make_instr(1'b0, 4'd10, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));      // unknown, closes
		send_instr(make_instr(1'b0, 4'd8, 7'd0, 7'd0, 7'd0, 7'd3, 7'd0));
		send_instr(make_instr(1'b0, 4'd2, 7'd0, 7'd0, 7'd0, 7'd4, 7'd0));
		send_instr(make_instr(1'b1, 4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));       // short close
		send_instr(make_instr(1'b1, 4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));
		send_instr(make_instr(1'b0, 4'd9, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127));
		send_instr(make_instr(1'b0, 4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0));
		send_instr(make_instr(1'b1, 4'd15, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127));
		// Leave three open for the width drop in the next test
		send_instr(make_instr(1'b0, 4'd3, 7'd10, 7'd0, 7'd0, 7'd20, 7'd0));
		send_instr(make_instr(1'b0, 4'd4, 7'd11, 7'd0, 7'd0, 7'd21, 7'd0));
		send_instr(make_instr(1'b0, 4'd5, 7'd0, 7'd12, 7'd0, 7'd0, 7'd22));
	endtask

	// Sweep widths (including out-of-range), lane legality and hint options.
	task automatic test_lane_settings();
		apply_settings(3'd1, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b0, 1'b1);
		run_random(12);
		apply_settings(3'd0, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
		run_random(10);
		apply_settings(3'd7, 10'h001, 10'h3FE, 10'h000, 10'h3FF, 1'b0, 1'b1);
		run_random(14);
		apply_settings(3'd2, 10'h000, 10'h000, 10'h000, 10'h000, 1'b1, 1'b1);
		run_random(6);
		apply_settings(3'd3, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
			1'b1, 1'b0);
		run_random(14);
		apply_settings(3'd4, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
	endtask

	// Long random stream; switch idling on and off per stretch.
	task automatic test_random_stream();
		repeat (3) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			run_random(20);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Hold the event port off while requests keep coming so the queue
	// fills and instr_stall rises; then pause until everything drains.
	task automatic test_backpressure();
		tx_idle_en  = 1'b0;
		rx_hold_req = HOLD_CYCLES;
		run_random(24);
		stop_sending();
		wait_drained();
		tx_idle_en = 1'b1;
		run_random(10);
	endtask

	// ------------------------------------------------------------------
	// Event side: stall generator, checker, watchdog
	// ------------------------------------------------------------------
	int rx_hold_left  = 0;
	int rx_stall_left = 0;

	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			evt_stall <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			evt_stall <= 1'b1;
		end else begin
			evt_stall     <= 1'b0;
			rx_stall_left = idle_length(rx_idle_en);
		end
	end

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0d expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	// Compare each accepted event against the oldest owed one.
	always @(posedge clk) begin : check_events
		vbf_pkg::evt_t want;
		if (arst_n && evt_valid === 1'b1 && evt_stall === 1'b0) begin
			if (expected_events.size() == 0) begin
				report_mismatch("event with none owed, event_res", 32'(evt.event_res), 0);
			end else begin
				want = expected_events.pop_front();
				if (evt.event_res !== want.event_res)
					report_mismatch("event_res", 32'(evt.event_res), 32'(want.event_res));
				if (evt.lane !== want.lane)
					report_mismatch("lane", 32'(evt.lane), 32'(want.lane));
				if (evt.bundle_size !== want.bundle_size)
					report_mismatch("bundle_size", 32'(evt.bundle_size), 32'(want.bundle_size));
				if (evt.emit_hint !== want.emit_hint)
					report_mismatch("emit_hint", 32'(evt.emit_hint), 32'(want.emit_hint));
				if (evt.last !== want.last)
					report_mismatch("last", 32'(evt.last), 32'(want.last));
			end
		end
	end

	// Abort when nothing moves on any port for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || psel || (instr_valid && !instr_stall) || (evt_valid && !evt_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lane_settings();
		test_random_stream();
		test_backpressure();
		stop_sending();
		wait_drained();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== vliw_bundle_former.f =====
design/vbf_pkg.sv
design/vbf_front.sv
design/vbf_queue.sv
design/vbf_back.sv
design/vliw_bundle_former.sv
design/vbf_checker.sv
tb/tb_vliw_bundle_former.sv
